// ===== rtl/core/qdc_pkg.sv =====
// ----------------------------------------------------------------------------
// qdc_pkg
// Shared types, codes and helpers for the quadrature detent counter.
// ----------------------------------------------------------------------------
package qdc_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int REG_W           = 16;
  localparam int TALLY_W         = 8;
  localparam int CFG_IDX_W       = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [1:0] EVENT_NONE  = 2'd0;
  localparam logic [1:0] EVENT_RAISE = 2'd1;
  localparam logic [1:0] EVENT_LOWER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;

  localparam logic [REG_W-1:0] MIN_RESET  = 16'd0;
  localparam logic [REG_W-1:0] MAX_RESET  = 16'hffff;
  localparam logic [REG_W-1:0] STEP_RESET = 16'd1;

  // phase differences taken modulo four
  localparam logic [1:0] PH_REST    = 2'd0;
  localparam logic [1:0] PH_FORWARD = 2'd1;
  localparam logic [1:0] PH_BACK    = 2'd3;

  localparam logic signed [TALLY_W-1:0] TALLY_MAX  = 8'sd127;
  localparam logic signed [TALLY_W-1:0] TALLY_MIN  = -8'sd128;
  localparam logic signed [TALLY_W-1:0] TALLY_ZERO = 8'sd0;

  typedef struct packed {
    logic             op;
    logic             pin_a;
    logic             pin_b;
    logic [REG_W-1:0] load_value;
  } item_t;

  typedef struct packed {
    logic [REG_W-1:0] min_value;
    logic [REG_W-1:0] max_value;
    logic [REG_W-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic [REG_W-1:0] position;
    logic [1:0]       detent_event;
  } result_t;

  function automatic logic [1:0] pins_to_phase(input logic a, input logic b);
    logic [1:0] ph;
    case ({a, b})
      2'b11:   ph = 2'd0;
      2'b01:   ph = 2'd1;
      2'b00:   ph = 2'd2;
      default: ph = 2'd3;
    endcase
    return ph;
  endfunction

endpackage

// ===== rtl/core/qdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// qdc_cfg_regs
// Clamp and step registers, written through the plain write port.
// ----------------------------------------------------------------------------
module qdc_cfg_regs import qdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_value <= MIN_RESET;
      cfg.max_value <= MAX_RESET;
      cfg.step_size <= STEP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MIN:  cfg.min_value <= wr_data;
        CFG_MAX:  cfg.max_value <= wr_data;
        CFG_STEP: cfg.step_size <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/qdc_tracker.sv =====
// ----------------------------------------------------------------------------
// qdc_tracker
// Phase tracking, detent tally and clamped position update for one item.
// ----------------------------------------------------------------------------
module qdc_tracker import qdc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int EXT_W = (VALUE_WIDTH > REG_W) ? VALUE_WIDTH : REG_W;
  localparam int AW    = EXT_W + 1;

  logic                      prev_a, prev_b;
  logic [1:0]                prev_phase;
  logic signed [TALLY_W-1:0] tally;
  logic [VALUE_WIDTH-1:0]    pos;

  logic                      prev_a_next, prev_b_next;
  logic [1:0]                prev_phase_next;
  logic signed [TALLY_W-1:0] tally_next;
  logic [VALUE_WIDTH-1:0]    pos_next;

  logic [1:0]                phase, dstep;
  logic                      changed;
  logic signed [TALLY_W-1:0] tally_adj;
  logic [1:0]                ev;

  logic [AW-1:0] pos_a, step_a, min_a, max_a, mask_a;
  logic [AW-1:0] sum, r1, r2, diff, d2, min_m, d_m;
  logic [VALUE_WIDTH-1:0] raised, lowered;
  logic [EXT_W-1:0] pos_ext;

  assign phase   = pins_to_phase(item.pin_a, item.pin_b);
  assign changed = (item.pin_a != prev_a) || (item.pin_b != prev_b);
  assign dstep   = phase - prev_phase;

  always_comb begin
    tally_adj = tally;
    if (dstep == PH_BACK && tally != TALLY_MAX) begin
      tally_adj = tally + 8'sd1;
    end else if (dstep == PH_FORWARD && tally != TALLY_MIN) begin
      tally_adj = tally - 8'sd1;
    end
  end

  assign pos_a  = AW'(pos);
  assign step_a = AW'(cfg.step_size);
  assign min_a  = AW'(cfg.min_value);
  assign max_a  = AW'(cfg.max_value);
  assign mask_a = AW'({VALUE_WIDTH{1'b1}});

  // raise: clamp at max, then at the value range
  assign sum    = pos_a + step_a;
  assign r1     = (sum > max_a) ? max_a : sum;
  assign r2     = (r1 > mask_a) ? mask_a : r1;
  assign raised = r2[VALUE_WIDTH-1:0];

  // lower: never wraps, clamp at min
  assign diff    = pos_a - step_a;
  assign d2      = (diff < min_a) ? min_a : diff;
  assign min_m   = min_a & mask_a;
  assign d_m     = d2 & mask_a;
  assign lowered = (pos_a < step_a) ? min_m[VALUE_WIDTH-1:0] : d_m[VALUE_WIDTH-1:0];

  always_comb begin
    prev_a_next     = prev_a;
    prev_b_next     = prev_b;
    prev_phase_next = prev_phase;
    tally_next      = tally;
    pos_next        = pos;
    ev              = EVENT_NONE;
    if (item.op == OP_LOAD) begin
      pos_next = VALUE_WIDTH'(EXT_W'(item.load_value));
    end else if (changed) begin
      tally_next = tally_adj;
      if (phase == PH_REST) begin
        if (tally_adj > TALLY_ZERO) begin
          pos_next = lowered;
          ev       = EVENT_LOWER;
        end else if (tally_adj < TALLY_ZERO) begin
          pos_next = raised;
          ev       = EVENT_RAISE;
        end
        tally_next = TALLY_ZERO;
      end
      prev_a_next     = item.pin_a;
      prev_b_next     = item.pin_b;
      prev_phase_next = phase;
    end
  end

  assign pos_ext             = EXT_W'(pos_next);
  assign result.position     = pos_ext[REG_W-1:0];
  assign result.detent_event = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a     <= 1'b0;
      prev_b     <= 1'b0;
      prev_phase <= PH_REST;
      tally      <= TALLY_ZERO;
      pos        <= '0;
    end else if (go) begin
      prev_a     <= prev_a_next;
      prev_b     <= prev_b_next;
      prev_phase <= prev_phase_next;
      tally      <= tally_next;
      pos        <= pos_next;
    end
  end

`ifndef SYNTHESIS
  a_load_sets_pos: assert property (@(posedge clk) disable iff (rst)
    go && item.op == OP_LOAD |=> pos == VALUE_WIDTH'(EXT_W'($past(item.load_value))))
    else $error("load did not set position");

  a_rest_clears_tally: assert property (@(posedge clk) disable iff (rst)
    go && item.op == OP_SAMPLE && changed && phase == PH_REST |=> tally == TALLY_ZERO)
    else $error("tally not cleared at rest phase");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(tally) && $stable(pos) && $stable(prev_phase))
    else $error("state changed without an item");
`endif

endmodule

// ===== rtl/core/quadrature_detent_counter.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_counter
// Quadrature encoder decoder with detent tally and clamped position value.
// ----------------------------------------------------------------------------
// One transaction is taken per clock while in_stall is low. Each accepted
// item passes an input register, the combinational step logic (phase map,
// tally, clamped add or subtract) and a result register. While a result
// waits under stall, one more item is held in the input register before the
// input side stalls.
module quadrature_detent_counter import qdc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic                 pin_a,
  input  logic                 pin_b,
  input  logic [REG_W-1:0]     load_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [REG_W-1:0]     position,
  output logic [1:0]           detent_event
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t res;
  result_t out_res;
  logic    in_take, advance;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  qdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  qdc_tracker #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .go     (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item <= '{op: op, pin_a: pin_a, pin_b: pin_b, load_value: load_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign position     = out_res.position;
  assign detent_event = out_res.detent_event;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room to advance");

  a_result_not_dropped: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("result withdrawn while stalled");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> detent_event == EVENT_NONE || detent_event == EVENT_RAISE ||
                  detent_event == EVENT_LOWER)
    else $error("invalid detent event code");
`endif

endmodule
